/* rtl/ctt_pkg.sv */
// ----------------------------------------------------------------------------
// ctt_pkg
// Shared types, codes and helpers for the callout timer table.
// ----------------------------------------------------------------------------
package ctt_pkg;

   localparam int SLOTS       = 16;
   localparam int SLOT_IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int MAX_RESULTS = 16;
   localparam int REP_CNT_W   = $clog2(MAX_RESULTS + 1);
   localparam int TICK_W      = 16;
   localparam int TAG_W       = 16;

   localparam logic [1:0] ACT_ADD  = 2'd0;
   localparam logic [1:0] ACT_DEL  = 2'd1;
   localparam logic [1:0] ACT_TICK = 2'd2;

   localparam logic [1:0] KIND_ADDED = 2'd0;
   localparam logic [1:0] KIND_FULL  = 2'd1;
   localparam logic [1:0] KIND_FIRED = 2'd2;

   typedef logic [SLOT_IDX_W-1:0] slot_idx_type;

   typedef struct packed {
      logic [1:0]       action;
      logic [15:0]      delay;
      logic [3:0]       slot;
      logic [TAG_W-1:0] tag;
   } req_type;

   typedef struct packed {
      logic [1:0]       kind;
      logic [3:0]       slot_id;
      logic [TAG_W-1:0] fired_tag;
      logic             last;
   } rsp_type;

   typedef struct packed {
      logic [TICK_W-1:0] ticks;
      logic [TAG_W-1:0]  tag;
   } entry_type;

   typedef struct packed {
      logic         we;
      slot_idx_type waddr;
      entry_type    wdata;
      logic         re;
      slot_idx_type raddr;
   } mem_req_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ADD,
      ST_TICK,
      ST_FLUSH
   } state_type;

   // Slot number as reported: low four bits of the index.
   function automatic logic [3:0] to_slot_id(input slot_idx_type idx);
      logic [SLOT_IDX_W+3:0] wide;
      wide = {4'b0000, idx};
      return wide[3:0];
   endfunction

endpackage

/* rtl/ctt_timer_ram.sv */
// ----------------------------------------------------------------------------
// ctt_timer_ram
// Per-slot count and tag store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ctt_timer_ram
   import ctt_pkg::*;
(
   input  logic        clock,
   input  mem_req_type mem_req,
   output entry_type   rdata
);

   entry_type mem [SLOTS];
   entry_type rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem[mem_req.waddr] <= mem_req.wdata;
      end
   end

   // Hold read data while no read is issued.
   always_ff @(posedge clock) begin
      if (mem_req.re) begin
         rdata_ff <= mem[mem_req.raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/callout_timer_table.sv */
// ----------------------------------------------------------------------------
// callout_timer_table
// Table of one-shot timers: add, delete and tick requests, fired reports.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one request (add, delete or tick); rsp_* carries results.
//   A request is taken when req_valid is high and req_stall is low; the
//   block raises req_stall while it works on an add or a tick request.
//   Add walks the active marks one slot per cycle, lowest first, and claims
//   the first free slot; it gives one result (added or full).
//   Delete drops the mark as the request is taken and gives no result.
//   Tick walks every slot through the count/tag RAM, one slot per cycle
//   unless held; the RAM read of slot i+1 overlaps the update of slot i.
//   Each fired slot gives one result; the report is held back one fire so
//   the final one can carry last.
//   At most MAX_RESULTS fires are reported per tick; later ones are freed.
//   Results sit in an output register; the next request is accepted while a
//   result waits there. A stalled receiver holds the walk only when a new
//   result has nowhere to go.
//   Reset clears the active marks at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module callout_timer_table
   import ctt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam slot_idx_type LAST_IDX = SLOT_IDX_W'(SLOTS - 1);

   state_type              state_ff, state_in;
   slot_idx_type           idx_ff, idx_in;
   logic [SLOTS-1:0]       active_ff, active_in;
   logic                   pend_valid_ff, pend_valid_in;
   rsp_type                pend_ff, pend_in;
   logic [REP_CNT_W-1:0]   rep_cnt_ff, rep_cnt_in;
   logic [TICK_W-1:0]      delay_ff, delay_in;
   logic [TAG_W-1:0]       tag_ff, tag_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   mem_req_type            mem_req;
   entry_type              rd_entry;
   logic                   out_free;
   logic                   rsp_load;
   rsp_type                rsp_next;
   logic                   fire;
   logic                   report;
   logic                   blocked;

   ctt_timer_ram u_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rdata   (rd_entry)
   );

   // Output register can take a new result this cycle.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Tick evaluation of the slot whose RAM data is present.
   assign fire    = active_ff[idx_ff] && (rd_entry.ticks <= TICK_W'(1));
   assign report  = fire && (rep_cnt_ff != REP_CNT_W'(MAX_RESULTS));
   assign blocked = report && pend_valid_ff && !out_free;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      active_in     = active_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rep_cnt_in    = rep_cnt_ff;
      delay_in      = delay_ff;
      tag_in        = tag_ff;
      mem_req       = '0;
      rsp_load      = 1'b0;
      rsp_next      = pend_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               delay_in = req_data.delay;
               tag_in   = req_data.tag;
               unique case (req_data.action)
                  ACT_ADD: begin
                     state_in = ST_ADD;
                     idx_in   = '0;
                  end
                  ACT_DEL: begin
                     // Drop the mark; out-of-range slots match nothing.
                     for (int i = 0; i < SLOTS; i++) begin
                        if (int'(req_data.slot) == i) begin
                           active_in[i] = 1'b0;
                        end
                     end
                  end
                  ACT_TICK: begin
                     state_in    = ST_TICK;
                     idx_in      = '0;
                     rep_cnt_in  = '0;
                     mem_req.re  = 1'b1;
                     mem_req.raddr = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_ADD: begin
            if (!active_ff[idx_ff]) begin
               if (out_free) begin
                  mem_req.we          = 1'b1;
                  mem_req.waddr       = idx_ff;
                  mem_req.wdata.ticks = delay_ff;
                  mem_req.wdata.tag   = tag_ff;
                  active_in[idx_ff]   = 1'b1;
                  rsp_load            = 1'b1;
                  rsp_next.kind       = KIND_ADDED;
                  rsp_next.slot_id    = to_slot_id(idx_ff);
                  rsp_next.fired_tag  = '0;
                  rsp_next.last       = 1'b1;
                  state_in            = ST_IDLE;
               end
            end else if (idx_ff == LAST_IDX) begin
               if (out_free) begin
                  rsp_load           = 1'b1;
                  rsp_next.kind      = KIND_FULL;
                  rsp_next.slot_id   = '0;
                  rsp_next.fired_tag = '0;
                  rsp_next.last      = 1'b1;
                  state_in           = ST_IDLE;
               end
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         ST_TICK: begin
            if (!blocked) begin
               if (fire) begin
                  active_in[idx_ff] = 1'b0;
               end else if (active_ff[idx_ff]) begin
                  mem_req.we          = 1'b1;
                  mem_req.waddr       = idx_ff;
                  mem_req.wdata.ticks = rd_entry.ticks - 1'b1;
                  mem_req.wdata.tag   = rd_entry.tag;
               end
               if (report) begin
                  // Release the previous fire; it is known not to be last.
                  if (pend_valid_ff) begin
                     rsp_load      = 1'b1;
                     rsp_next      = pend_ff;
                     rsp_next.last = 1'b0;
                  end
                  pend_valid_in     = 1'b1;
                  pend_in.kind      = KIND_FIRED;
                  pend_in.slot_id   = to_slot_id(idx_ff);
                  pend_in.fired_tag = rd_entry.tag;
                  pend_in.last      = 1'b0;
                  rep_cnt_in        = rep_cnt_ff + 1'b1;
               end
               if (idx_ff == LAST_IDX) begin
                  state_in = ST_FLUSH;
               end else begin
                  mem_req.re    = 1'b1;
                  mem_req.raddr = idx_ff + 1'b1;
                  idx_in        = idx_ff + 1'b1;
               end
            end
         end

         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_load      = 1'b1;
               rsp_next      = pend_ff;
               rsp_next.last = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register: load a new result, or hold while stalled.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_in       = rsp_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         idx_ff        <= '0;
         active_ff     <= '0;
         pend_valid_ff <= 1'b0;
         rep_cnt_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         active_ff     <= active_in;
         pend_valid_ff <= pend_valid_in;
         rep_cnt_ff    <= rep_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff  <= pend_in;
      delay_ff <= delay_in;
      tag_ff   <= tag_in;
      rsp_ff   <= rsp_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A held-back fire exists only inside a tick walk.
   a_pend_in_tick: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> (state_ff == ST_TICK || state_ff == ST_FLUSH))
      else $error("pending fire outside tick walk");

   // The overlapped update never writes the entry being read.
   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (mem_req.we && mem_req.re) |-> (mem_req.waddr != mem_req.raddr))
      else $error("RAM read and write hit the same slot");

   // A claimed slot is marked active right after the added result loads.
   a_add_marks: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && rsp_next.kind == KIND_ADDED) |=> active_ff[$past(idx_ff)])
      else $error("added slot not marked active");

   // Fire reports per tick stay within the limit.
   a_rep_limit: assert property (@(posedge clock) disable iff (reset)
      rep_cnt_ff <= REP_CNT_W'(MAX_RESULTS))
      else $error("fire report count over limit");

endmodule
